>>> sv/mi3_pkg.sv
// Shared types, widths and constant tables of the 3x3 matrix inverse.
`default_nettype none

package mi3_pkg;

    // Width of one matrix entry and of one inverse entry.
    localparam int ENTRY_WIDTH = 32;

    // Quotient bits kept before rounding: the entry width plus one rounding bit below its LSB.
    localparam int QUOT_BITS = ENTRY_WIDTH + 1;

    // Cycles from an accepted request to its result strobe.
    localparam int LATENCY = 8 + QUOT_BITS;

    // Request: the nine matrix entries in row-major order.
    typedef struct packed {
        logic signed [ENTRY_WIDTH-1:0] m0;
        logic signed [ENTRY_WIDTH-1:0] m1;
        logic signed [ENTRY_WIDTH-1:0] m2;
        logic signed [ENTRY_WIDTH-1:0] m3;
        logic signed [ENTRY_WIDTH-1:0] m4;
        logic signed [ENTRY_WIDTH-1:0] m5;
        logic signed [ENTRY_WIDTH-1:0] m6;
        logic signed [ENTRY_WIDTH-1:0] m7;
        logic signed [ENTRY_WIDTH-1:0] m8;
    } t_mi3_req;

    // Result: the nine inverse entries and the singular flag.
    typedef struct packed {
        logic signed [ENTRY_WIDTH-1:0] r0;
        logic signed [ENTRY_WIDTH-1:0] r1;
        logic signed [ENTRY_WIDTH-1:0] r2;
        logic signed [ENTRY_WIDTH-1:0] r3;
        logic signed [ENTRY_WIDTH-1:0] r4;
        logic signed [ENTRY_WIDTH-1:0] r5;
        logic signed [ENTRY_WIDTH-1:0] r6;
        logic signed [ENTRY_WIDTH-1:0] r7;
        logic signed [ENTRY_WIDTH-1:0] r8;
        logic                          singular;
    } t_mi3_rsp;

    // Cofactor k is m[COF_A[k]] * m[COF_B[k]] - m[COF_C[k]] * m[COF_D[k]].
    typedef int t_idx_tab [9];
    localparam t_idx_tab COF_A = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam t_idx_tab COF_B = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam t_idx_tab COF_C = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam t_idx_tab COF_D = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

`default_nettype wire

>>> sv/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate, fully pipelined.
//
// Usage: drive the nine Q12.20 entries on i_req and raise start for one cycle.
// A request is taken at each rising edge where start is high and busy is low.
// busy never rises, so one matrix can be taken in every cycle.
// Each result appears on o_rsp for one cycle with o_done high, in request
// order. Results are Q8.24, rounded to nearest with halves away from zero,
// and saturated. A matrix with a zero determinant gives all zeros and
// singular. The pipeline chain is: products, cofactors, split determinant
// multiply (two stages), determinant sum, magnitudes, range check, then one
// restoring division step per quotient bit (33 stages, nine lanes sharing
// one divisor), then rounding and saturation into the output register.
// Throughput is one matrix per cycle.
// Reset (synchronous, active low) clears every valid bit; requests in
// flight are dropped. The receiver cannot stall, so no backpressure exists.
`default_nettype none

module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int IN_FRAC_BITS  = 20,
    parameter int OUT_FRAC_BITS = 24
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_mi3_req i_req,
    output logic          busy,
    output logic          o_done,
    output t_mi3_rsp      o_rsp
);

    localparam int W    = ENTRY_WIDTH;
    localparam int PW   = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int PPW  = 2 * W + 1;
    localparam int TW   = 3 * W + 1;
    localparam int DSW  = 3 * W + 3;
    localparam int CMW  = 2 * W;
    localparam int DMW  = 3 * W + 2;
    localparam int QB   = QUOT_BITS;
    localparam int SH   = IN_FRAC_BITS + OUT_FRAC_BITS + 1;
    localparam int RW   = CMW + SH;
    localparam int XW   = (RW > DMW + QB) ? RW : DMW + QB;

    logic signed [W-1:0] m_in [9];

    // Unpack the request into an indexable array.
    assign m_in[0] = i_req.m0;
    assign m_in[1] = i_req.m1;
    assign m_in[2] = i_req.m2;
    assign m_in[3] = i_req.m3;
    assign m_in[4] = i_req.m4;
    assign m_in[5] = i_req.m5;
    assign m_in[6] = i_req.m6;
    assign m_in[7] = i_req.m7;
    assign m_in[8] = i_req.m8;

    assign busy = 1'b0;

    // Stage 1: the eighteen entry products.
    logic                 r1_vld;
    logic signed [PW-1:0] r1_pa [9];
    logic signed [PW-1:0] r1_pb [9];
    logic signed [W-1:0]  r1_mc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
        for (int k = 0; k < 9; k++) begin
            r1_pa[k] <= PW'(m_in[COF_A[k]]) * PW'(m_in[COF_B[k]]);
            r1_pb[k] <= PW'(m_in[COF_C[k]]) * PW'(m_in[COF_D[k]]);
        end
        r1_mc[0] <= m_in[0];
        r1_mc[1] <= m_in[3];
        r1_mc[2] <= m_in[6];
    end

    // Stage 2: cofactors.
    logic                 r2_vld;
    logic signed [CW-1:0] r2_cof [9];
    logic signed [W-1:0]  r2_mc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        for (int k = 0; k < 9; k++) begin
            r2_cof[k] <= CW'(r1_pa[k]) - CW'(r1_pb[k]);
        end
        r2_mc <= r1_mc;
    end

    // Stage 3: determinant terms as two partial products each.
    logic                  r3_vld;
    logic signed [PPW-1:0] r3_lo [3];
    logic signed [PPW-1:0] r3_hi [3];
    logic signed [CW-1:0]  r3_cof [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        for (int j = 0; j < 3; j++) begin
            r3_lo[j] <= PPW'(r2_mc[j]) * PPW'($signed({1'b0, r2_cof[j][W-1:0]}));
            r3_hi[j] <= PPW'(r2_mc[j]) * PPW'($signed(r2_cof[j][CW-1:W]));
        end
        r3_cof <= r2_cof;
    end

    // Stage 4: recombine the partial products.
    logic                 r4_vld;
    logic signed [TW-1:0] r4_term [3];
    logic signed [CW-1:0] r4_cof [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        for (int j = 0; j < 3; j++) begin
            r4_term[j] <= (TW'(r3_hi[j]) <<< W) + TW'(r3_lo[j]);
        end
        r4_cof <= r3_cof;
    end

    // Stage 5: determinant.
    logic                  r5_vld;
    logic signed [DSW-1:0] r5_det;
    logic signed [CW-1:0]  r5_cof [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_det <= DSW'(r4_term[0]) + DSW'(r4_term[1]) + DSW'(r4_term[2]);
        r5_cof <= r4_cof;
    end

    // Stage 6: signs and magnitudes.
    logic             r6_vld;
    logic [DMW-1:0]   r6_dmag;
    logic             r6_sing;
    logic [CMW-1:0]   r6_cmag [9];
    logic             r6_neg [9];
    logic [DSW-1:0]   n_dabs;
    logic [CW-1:0]    n_cabs [9];

    always_comb begin
        n_dabs = r5_det[DSW-1] ? DSW'(-r5_det) : DSW'(r5_det);
        for (int k = 0; k < 9; k++) begin
            n_cabs[k] = r5_cof[k][CW-1] ? CW'(-r5_cof[k]) : CW'(r5_cof[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_dmag <= n_dabs[DMW-1:0];
        r6_sing <= (r5_det == '0);
        for (int k = 0; k < 9; k++) begin
            r6_cmag[k] <= n_cabs[k][CMW-1:0];
            r6_neg[k]  <= r5_cof[k][CW-1] ^ r5_det[DSW-1];
        end
    end

    // Stage 7: scaled numerators and the out-of-range check.
    logic           r7_vld;
    logic [XW-1:0]  r7_rem [9];
    logic           r7_ovf [9];
    logic           r7_neg [9];
    logic [XW-1:0]  r7_den;
    logic           r7_sing;
    logic [XW-1:0]  n7_rem [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n7_rem[k] = XW'(r6_cmag[k]) << SH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
        for (int k = 0; k < 9; k++) begin
            r7_rem[k] <= n7_rem[k];
            r7_ovf[k] <= n7_rem[k] >= (XW'(r6_dmag) << QB);
        end
        r7_neg  <= r6_neg;
        r7_den  <= XW'(r6_dmag);
        r7_sing <= r6_sing;
    end

    // Division stages: one restoring step per quotient bit, MSB first.
    logic           rd_vld  [QB];
    logic [XW-1:0]  rd_rem  [QB][9];
    logic [QB-1:0]  rd_q    [QB][9];
    logic           rd_ovf  [QB][9];
    logic           rd_neg  [QB][9];
    logic [XW-1:0]  rd_den  [QB];
    logic           rd_sing [QB];

    for (genvar s = 0; s < QB; s++) begin : g_div
        localparam int BIT = QB - 1 - s;

        logic           a_vld;
        logic [XW-1:0]  a_rem [9];
        logic [QB-1:0]  a_q [9];
        logic           a_ovf [9];
        logic           a_neg [9];
        logic [XW-1:0]  a_den;
        logic           a_sing;
        logic [XW-1:0]  n_rem [9];
        logic [QB-1:0]  n_q [9];

        // Stage input: the range check for the first step, else the previous step.
        if (s == 0) begin : g_first
            always_comb begin
                a_vld  = r7_vld;
                a_rem  = r7_rem;
                a_ovf  = r7_ovf;
                a_neg  = r7_neg;
                a_den  = r7_den;
                a_sing = r7_sing;
                for (int k = 0; k < 9; k++) begin
                    a_q[k] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                a_vld  = rd_vld[s-1];
                a_rem  = rd_rem[s-1];
                a_q    = rd_q[s-1];
                a_ovf  = rd_ovf[s-1];
                a_neg  = rd_neg[s-1];
                a_den  = rd_den[s-1];
                a_sing = rd_sing[s-1];
            end
        end

        // Trial subtraction of the shifted divisor in every lane.
        always_comb begin
            for (int k = 0; k < 9; k++) begin
                n_rem[k] = a_rem[k];
                n_q[k]   = a_q[k];
                if (a_rem[k] >= (a_den << BIT)) begin
                    n_rem[k] = a_rem[k] - (a_den << BIT);
                    n_q[k]   = a_q[k] | (QB'(1) << BIT);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rd_vld[s] <= 1'b0;
            end else begin
                rd_vld[s] <= a_vld;
            end
            rd_rem[s]  <= n_rem;
            rd_q[s]    <= n_q;
            rd_ovf[s]  <= a_ovf;
            rd_neg[s]  <= a_neg;
            rd_den[s]  <= a_den;
            rd_sing[s] <= a_sing;
        end
    end

    // Output stage: round half away from zero, saturate, apply the sign, and zero singular results.
    logic            r_done;
    t_mi3_rsp        r_rsp;
    t_mi3_rsp        n_rsp;
    logic [QB:0]     n_inc [9];
    logic [QB-1:0]   n_rnd [9];
    logic [QB-1:0]   n_lim [9];
    logic [QB-1:0]   n_mag [9];
    logic [QB-1:0]   n_val [9];
    logic [W-1:0]    n_res [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_inc[k] = {1'b0, rd_q[QB-1][k]} + (QB+1)'(1);
            n_rnd[k] = n_inc[k][QB:1];
            n_lim[k] = rd_neg[QB-1][k] ? (QB'(1) << (W - 1))
                                       : (QB'(1) << (W - 1)) - QB'(1);
            n_mag[k] = (rd_ovf[QB-1][k] || (n_rnd[k] > n_lim[k])) ? n_lim[k] : n_rnd[k];
            n_val[k] = rd_neg[QB-1][k] ? QB'(-n_mag[k]) : n_mag[k];
            n_res[k] = rd_sing[QB-1] ? '0 : n_val[k][W-1:0];
        end
        n_rsp.r0       = n_res[0];
        n_rsp.r1       = n_res[1];
        n_rsp.r2       = n_res[2];
        n_rsp.r3       = n_res[3];
        n_rsp.r4       = n_res[4];
        n_rsp.r5       = n_res[5];
        n_rsp.r6       = n_res[6];
        n_rsp.r7       = n_res[7];
        n_rsp.r8       = n_res[8];
        n_rsp.singular = rd_sing[QB-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= rd_vld[QB-1];
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

>>> sv/mi3_checker.sv
// Port-level checker for the 3x3 matrix inverse, bound to the top level.
`default_nettype none

module mi3_checker
    import mi3_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     o_done,
    input wire t_mi3_rsp o_rsp
);

    // The block never refuses a request.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Every accepted request is followed by its result on o_done.
    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("result missing after request");

    // No result appears without a matching request.
    a_done_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result without request");

    // A singular matrix gives an all-zero inverse.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.singular) |->
            (o_rsp.r0 == '0 && o_rsp.r1 == '0 && o_rsp.r2 == '0 &&
             o_rsp.r3 == '0 && o_rsp.r4 == '0 && o_rsp.r5 == '0 &&
             o_rsp.r6 == '0 && o_rsp.r7 == '0 && o_rsp.r8 == '0))
        else $error("singular result not zero");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire
